// ===== hw/rtl/tvi_pkg.sv =====
// Shared types, constants and status codes for the timestamped vector interpolator.
package tvi_pkg;
	localparam int unsigned TableDepthDefault = 64;
	localparam int unsigned LanesDefault      = 3;
	localparam int unsigned ValueFields       = 3;

	typedef enum logic [1:0] {
		ST_ADDED     = 2'd0,
		ST_DROPPED   = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_GET = 1'b1;

	// Lane job handed from the sequencer to each lane.
	typedef struct packed {
		logic        start;
		logic        bypass;
		logic [31:0] num;
		logic [31:0] den;
	} lane_cmd_t;
endpackage

// ===== hw/rtl/tvi_lane.sv =====
// One interpolation lane: y1 + (y2 - y1) * num / den with a serial divider.
module tvi_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  tvi_pkg::lane_cmd_t cmd,
	input  logic signed [31:0] y1,
	input  logic signed [31:0] y2,
	output logic               done,
	output logic signed [31:0] y
);
	import tvi_pkg::*;

	logic               busy_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	logic signed [31:0] base_q;
	logic [32:0]        mag_q;
	logic [31:0]        num_q;
	logic [31:0]        den_q;
	logic [64:0]        prod_q;
	logic [63:0]        quo_q;
	logic [32:0]        rem_q;
	logic               mul_q;
	logic               fin_q;

	logic signed [32:0] diff;
	logic [33:0]        trial;
	logic [63:0]        qfull;

	assign diff  = 33'(y2) - 33'(y1);
	assign trial = {rem_q, prod_q[63 - cnt_q]} - {2'b0, den_q};
	assign qfull = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			mul_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (cmd.start) begin
				base_q <= y1;
				neg_q  <= diff[32];
				mag_q  <= diff[32] ? 33'(-diff) : 33'(diff);
				num_q  <= cmd.num;
				den_q  <= cmd.den;
				if (!cmd.bypass) mul_q <= 1'b1;
			end else if (mul_q) begin
				// register the product before the divider
				prod_q <= 65'(mag_q) * 65'(num_q);
				mul_q  <= 1'b0;
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				if (!trial[33]) begin
					rem_q <= trial[32:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], prod_q[63 - cnt_q]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					mul_q  <= 1'b0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			if (cmd.start && cmd.bypass) begin
				y    <= y1;
				done <= 1'b1;
			end else if (fin_q) begin
				y    <= neg_q ? (base_q - qfull[31:0]) : (base_q + qfull[31:0]);
				done <= 1'b1;
			end else begin
				done <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_q <= 1'b0;
		else fin_q <= busy_q && cnt_q == 6'd63;
	end
endmodule

// ===== hw/rtl/timestamped_vector_interpolator.sv =====
// Top level: sorted sample table, sequencer and lane merge.
//
// Channels: in_valid/in_ready take one word (kind, timestamp, value_0..2);
// out_valid/out_ready deliver one result word per input word; cfg_valid/
// cfg_ready write vector_length while the block is idle.
// An add scans upward for its slot (S_FIND_W, S_FIND per entry), then
// shifts later entries up one by one (S_SHIFT_RD, S_SHIFT_WR). A get
// scans from the top down for the bracketing pair (S_GSCAN, S_GSCAN_W per
// entry), then runs every lane through a registered multiply and a
// 64-step restoring divider. A get that lands on the newest sample skips
// the divider; a get past the newest sample or on an empty table is
// answered as not found without the lanes. One item is in work at a time;
// the input is taken again once the result word has been accepted.
// Reset empties the table (count to zero) and sets vector_length to 3; the
// table memory itself is not cleared. A stalled receiver holds the result
// register and the next word waits at the input.
module timestamped_vector_interpolator #(
	parameter int unsigned TABLE_DEPTH = tvi_pkg::TableDepthDefault,
	parameter int unsigned LANES       = tvi_pkg::LanesDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [31:0]        timestamp,
	input  logic signed [31:0] value_0,
	input  logic signed [31:0] value_1,
	input  logic signed [31:0] value_2,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [31:0]        result_time,
	output logic signed [31:0] result_0,
	output logic signed [31:0] result_1,
	output logic signed [31:0] result_2,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         vector_length
);
	import tvi_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned VW = 32 * LANES;

	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_FIND_W, S_SHIFT_RD, S_SHIFT_WR, S_WRITE,
		S_GSCAN, S_GSCAN_W, S_RD_LO, S_RD_HI, S_LANES, S_OUT
	} state_t;

	logic [31:0]   time_mem [TABLE_DEPTH];
	logic [VW-1:0] val_mem  [TABLE_DEPTH];

	state_t        state_q;
	logic [1:0]    vlen_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   t_q;
	logic [VW-1:0] vin_q;
	logic [1:0]    nl_q;

	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_time_q;
	logic [VW-1:0] rd_val_q;
	logic          we;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_time;
	logic [VW-1:0] wr_val;

	logic [31:0]   x1_q;
	logic [VW-1:0] v1_q;
	logic          at_end_q;

	logic [LANES-1:0]      lane_done;
	logic [LANES-1:0]      done_q;
	logic [VW-1:0]         lane_y;
	logic [VW-1:0]         res_q;
	lane_cmd_t             cmd;

	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[wr_addr] <= wr_time;
			val_mem[wr_addr]  <= wr_val;
		end
		rd_time_q <= time_mem[rd_addr];
		rd_val_q  <= val_mem[rd_addr];
	end

	// hold the input until the previous result word has drained
	assign in_ready  = (state_q == S_IDLE) && !out_valid;
	assign cfg_ready = (state_q == S_IDLE);

	// lanes in use, masked per lane
	logic [1:0] nl;
	always_comb begin
		nl = (vlen_q == 2'd0) ? 2'd1 : vlen_q;
		if (32'(nl) > LANES) nl = 2'(LANES);
	end

	logic [VW-1:0] vin_masked;
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (l < int'(nl) && l < int'(ValueFields))
				vin_masked[32*l +: 32] = (l == 0) ? value_0 : (l == 1) ? value_1 : value_2;
			else
				vin_masked[32*l +: 32] = '0;
		end
	end

	always_comb begin
		rd_addr = idx_q[AW-1:0];
		we      = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_time = rd_time_q;
		wr_val  = rd_val_q;
		case (state_q)
			S_SHIFT_RD: rd_addr = AW'(idx_q - CW'(1));
			S_SHIFT_WR: we = 1'b1;
			S_WRITE: begin
				we      = 1'b1;
				wr_time = t_q;
				wr_val  = vin_q;
			end
			S_GSCAN:  rd_addr = AW'(idx_q - CW'(1));
			S_RD_HI:  rd_addr = idx_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vlen_q    <= 2'd3;
			count_q   <= '0;
			idx_q     <= '0;
			out_valid <= 1'b0;
			cmd       <= '0;
			done_q    <= '0;
		end else begin
			cmd.start <= (state_q == S_RD_LO);
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) vlen_q <= vector_length;
					if (in_valid && in_ready) begin
						t_q    <= timestamp;
						vin_q  <= vin_masked;
						nl_q   <= nl;
						idx_q  <= (kind == KIND_ADD) ? '0 : count_q;
						if (kind == KIND_ADD) begin
							if (32'(count_q) >= TABLE_DEPTH) begin
								status      <= ST_DROPPED;
								result_time <= '0;
								res_q       <= '0;
								state_q     <= S_OUT;
							end else if (count_q == '0) begin
								state_q <= S_WRITE;
							end else begin
								state_q <= S_FIND_W;
							end
						end else begin
							if (count_q == '0) begin
								status      <= ST_NOT_FOUND;
								result_time <= '0;
								res_q       <= '0;
								state_q     <= S_OUT;
							end else begin
								state_q <= S_GSCAN;
							end
						end
					end
				end
				// memory read of idx_q in flight
				S_FIND_W: state_q <= S_FIND;
				S_FIND: begin
					if (rd_time_q <= t_q) begin
						if (idx_q + CW'(1) == count_q) begin
							idx_q   <= count_q;
							state_q <= S_WRITE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_FIND_W;
						end
					end else begin
						// slot found; shift from the top down to it
						x1_q[CW-1:0] <= idx_q;
						idx_q        <= count_q;
						state_q      <= S_SHIFT_RD;
					end
				end
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					if (idx_q - CW'(1) == x1_q[CW-1:0]) begin
						idx_q   <= x1_q[CW-1:0];
						state_q <= S_WRITE;
					end else begin
						idx_q   <= idx_q - CW'(1);
						state_q <= S_SHIFT_RD;
					end
				end
				S_WRITE: begin
					count_q     <= count_q + CW'(1);
					status      <= ST_ADDED;
					result_time <= '0;
					res_q       <= '0;
					state_q     <= S_OUT;
				end
				S_GSCAN: state_q <= S_GSCAN_W;
				S_GSCAN_W: begin
					// rd_time_q holds entry idx_q-1
					if (idx_q == count_q && rd_time_q < t_q) begin
						status      <= ST_NOT_FOUND;
						result_time <= '0;
						res_q       <= '0;
						state_q     <= S_OUT;
					end else if (rd_time_q <= t_q) begin
						x1_q     <= rd_time_q;
						v1_q     <= rd_val_q;
						at_end_q <= (idx_q == count_q);
						state_q  <= S_RD_HI;
					end else if (idx_q == CW'(1)) begin
						x1_q     <= '0;
						v1_q     <= '0;
						at_end_q <= 1'b0;
						idx_q    <= '0;
						state_q  <= S_RD_HI;
					end else begin
						idx_q   <= idx_q - CW'(1);
						state_q <= S_GSCAN;
					end
				end
				S_RD_HI: state_q <= S_RD_LO;
				S_RD_LO: begin
					cmd.bypass <= at_end_q;
					cmd.num    <= t_q - x1_q;
					cmd.den    <= rd_time_q - x1_q;
					done_q     <= '0;
					state_q    <= S_LANES;
				end
				S_LANES: begin
					done_q <= done_q | lane_done;
					for (int l = 0; l < LANES; l++)
						if (lane_done[l]) res_q[32*l +: 32] <= lane_y[32*l +: 32];
					if ((done_q | lane_done) == '1) begin
						status      <= ST_FOUND;
						result_time <= t_q;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					// merge: zero lanes not in use
					for (int l = 0; l < LANES; l++)
						if (l >= int'(nl_q)) res_q[32*l +: 32] <= '0;
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_valid && out_ready && state_q != S_OUT) out_valid <= 1'b0;
		end
	end

	logic [VW-1:0] hi_val;
	assign hi_val = rd_val_q;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		tvi_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.y1     (v1_q[32*l +: 32]),
			.y2     (hi_val[32*l +: 32]),
			.done   (lane_done[l]),
			.y      (lane_y[32*l +: 32])
		);
	end

	assign result_0 = res_q[31:0];
	assign result_1 = (LANES > 1) ? res_q[32*(LANES>1 ? 1 : 0) +: 32] & {32{LANES > 1}} : '0;
	assign result_2 = (LANES > 2) ? res_q[32*(LANES>2 ? 2 : 0) +: 32] & {32{LANES > 2}} : '0;
endmodule
